// ----- hdl/greedy_tile_rect_merge_defines.svh -----
// ----------------------------------------------------------------------------
// Greedy tile rectangle merge: assertion macros
// Shared property macros for the concurrent checks of the merge block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_TILE_RECT_MERGE_DEFINES_SVH
`define GREEDY_TILE_RECT_MERGE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GTRM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GTRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gtrm_pkg.sv -----
// ----------------------------------------------------------------------------
// Greedy tile rectangle merge: shared package
// Grid defaults, field widths and the controller-to-datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtrm_pkg;

    // Default grid size.
    localparam int GRID_WIDTH_DEF  = 8;
    localparam int GRID_HEIGHT_DEF = 8;

    // Fixed field widths.
    localparam int TYPE_W  = 8;
    localparam int COORD_W = 3;
    localparam int EXT_W   = 4;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PROBE_SCAN,
        OP_PROBE_RUN,
        OP_PROBE_DOWN,
        OP_TAKE_START,
        OP_RUN_GROW,
        OP_DOWN_STEP,
        OP_DOWN_GROW,
        OP_ADVANCE,
        OP_PUSH,
        OP_FLUSH
    } dp_op_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic start_ok;
        logic take_ok;
        logic run_room;
        logic down_room;
        logic row_done;
        logic scan_last;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/gtrm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Greedy tile rectangle merge: controller
// Sequences tile loading, the raster scan, run and row extension, and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtrm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                last_tile,
    output logic                     in_ready,
    input  wire gtrm_pkg::dp_status_t status,
    output gtrm_pkg::dp_op_t         op
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RUN_RD,
        ST_RUN_CHK,
        ST_DOWN_RD,
        ST_DOWN_CHK,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        op         = gtrm_pkg::OP_NONE;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    op = gtrm_pkg::OP_LOAD;
                    if (last_tile)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                op         = gtrm_pkg::OP_PROBE_SCAN;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (status.start_ok)
                begin
                    op         = gtrm_pkg::OP_TAKE_START;
                    state_next = ST_RUN_RD;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    op         = gtrm_pkg::OP_ADVANCE;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_RUN_RD:
            begin
                if (status.run_room)
                begin
                    op         = gtrm_pkg::OP_PROBE_RUN;
                    state_next = ST_RUN_CHK;
                end
                else
                begin
                    state_next = ST_DOWN_RD;
                end
            end
            ST_RUN_CHK:
            begin
                if (status.take_ok)
                begin
                    op         = gtrm_pkg::OP_RUN_GROW;
                    state_next = ST_RUN_RD;
                end
                else
                begin
                    state_next = ST_DOWN_RD;
                end
            end
            ST_DOWN_RD:
            begin
                if (status.down_room)
                begin
                    op         = gtrm_pkg::OP_PROBE_DOWN;
                    state_next = ST_DOWN_CHK;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DOWN_CHK:
            begin
                if (status.take_ok)
                begin
                    op         = status.row_done ? gtrm_pkg::OP_DOWN_GROW
                                                 : gtrm_pkg::OP_DOWN_STEP;
                    state_next = ST_DOWN_RD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // The held rectangle moves out only when the output is free.
                if (!status.pend_valid || status.out_free)
                begin
                    op         = gtrm_pkg::OP_PUSH;
                    state_next = status.scan_last ? ST_FLUSH : ST_SCAN_RD;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    op         = gtrm_pkg::OP_FLUSH;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_LOAD);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gtrm_dp.sv -----
// ----------------------------------------------------------------------------
// Greedy tile rectangle merge: datapath
// Tile memory, covered bits, scan counters, held rectangle and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtrm_dp #(
    parameter int GRID_WIDTH  = gtrm_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gtrm_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gtrm_pkg::dp_op_t              op,
    input  wire logic [gtrm_pkg::TYPE_W-1:0]   tile_type,
    input  wire logic                          last_tile,
    output gtrm_pkg::dp_status_t               status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gtrm_pkg::TYPE_W-1:0]        rect_type,
    output logic [gtrm_pkg::COORD_W-1:0]       rect_x,
    output logic [gtrm_pkg::COORD_W-1:0]       rect_y,
    output logic [gtrm_pkg::EXT_W-1:0]         rect_width,
    output logic [gtrm_pkg::EXT_W-1:0]         rect_height,
    output logic                               rect_valid,
    output logic                               last_rect
);

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int SUM_W      = gtrm_pkg::EXT_W + 1;

    // Tile memory and its registered read port.
    logic [gtrm_pkg::TYPE_W-1:0] mem [CELL_COUNT];
    logic [gtrm_pkg::TYPE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]            rd_idx_reg;

    logic [IDX_W-1:0]            load_idx_reg;
    logic [IDX_W-1:0]            limit_reg;
    logic [CELL_COUNT-1:0]       cov_reg;

    // Scan position and the rectangle being grown.
    logic [gtrm_pkg::COORD_W-1:0] cx_reg;
    logic [gtrm_pkg::COORD_W-1:0] cy_reg;
    logic [gtrm_pkg::EXT_W-1:0]   rw_reg;
    logic [gtrm_pkg::EXT_W-1:0]   rh_reg;
    logic [gtrm_pkg::EXT_W-1:0]   ri_reg;
    logic [gtrm_pkg::TYPE_W-1:0]  typ_reg;

    // Held rectangle, waiting to learn whether it is the last one.
    logic                         pend_valid_reg;
    logic [gtrm_pkg::TYPE_W-1:0]  pend_type_reg;
    logic [gtrm_pkg::COORD_W-1:0] pend_x_reg;
    logic [gtrm_pkg::COORD_W-1:0] pend_y_reg;
    logic [gtrm_pkg::EXT_W-1:0]   pend_w_reg;
    logic [gtrm_pkg::EXT_W-1:0]   pend_h_reg;

    // Output register.
    logic                         out_valid_reg;
    logic [gtrm_pkg::TYPE_W-1:0]  out_type_reg;
    logic [gtrm_pkg::COORD_W-1:0] out_x_reg;
    logic [gtrm_pkg::COORD_W-1:0] out_y_reg;
    logic [gtrm_pkg::EXT_W-1:0]   out_w_reg;
    logic [gtrm_pkg::EXT_W-1:0]   out_h_reg;
    logic                         out_rv_reg;
    logic                         out_last_reg;

    logic [IDX_W-1:0]            probe_idx;
    logic [gtrm_pkg::TYPE_W-1:0] eff_type;
    logic                        cov_hit;
    logic [CELL_COUNT-1:0]       row_mask;
    logic                        out_free;
    logic                        out_load;
    logic                        col_last;
    int                          px;
    int                          py;
    int                          row_base;

    // Probe address for the scan, run and row checks.
    always_comb
    begin
        px = int'(cx_reg);
        py = int'(cy_reg);
        case (op)
            gtrm_pkg::OP_PROBE_RUN:
            begin
                px = int'(cx_reg) + int'(rw_reg);
            end
            gtrm_pkg::OP_PROBE_DOWN:
            begin
                px = int'(cx_reg) + int'(ri_reg);
                py = int'(cy_reg) + int'(rh_reg);
            end
            default:
            begin
                px = int'(cx_reg);
            end
        endcase
        probe_idx = IDX_W'(py * GRID_WIDTH + px);
    end

    // Cells past the final tile read as empty.
    assign eff_type = (rd_idx_reg <= limit_reg) ? rd_data_reg : '0;
    assign cov_hit  = cov_reg[rd_idx_reg];
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = ((op == gtrm_pkg::OP_PUSH) && pend_valid_reg) ||
                      (op == gtrm_pkg::OP_FLUSH);
    assign col_last = (cx_reg == gtrm_pkg::COORD_W'(GRID_WIDTH - 1));

    // Covered mask of the run in the row below the rectangle.
    always_comb
    begin
        row_base = (int'(cy_reg) + int'(rh_reg)) * GRID_WIDTH + int'(cx_reg);
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            row_mask[k] = (k >= row_base) && (k < row_base + int'(rw_reg));
        end
    end

    // Status back to the controller.
    always_comb
    begin
        status.start_ok   = (eff_type != '0) && !cov_hit;
        status.take_ok    = (eff_type == typ_reg) && !cov_hit;
        status.run_room   = (SUM_W'(cx_reg) + SUM_W'(rw_reg)) < SUM_W'(GRID_WIDTH);
        status.down_room  = (SUM_W'(cy_reg) + SUM_W'(rh_reg)) < SUM_W'(GRID_HEIGHT);
        status.row_done   = (SUM_W'(ri_reg) + SUM_W'(1)) == SUM_W'(rw_reg);
        status.scan_last  = col_last && (cy_reg == gtrm_pkg::COORD_W'(GRID_HEIGHT - 1));
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    // Tile memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (op == gtrm_pkg::OP_LOAD)
        begin
            mem[load_idx_reg] <= tile_type;
        end
        if ((op == gtrm_pkg::OP_PROBE_SCAN) || (op == gtrm_pkg::OP_PROBE_RUN) ||
            (op == gtrm_pkg::OP_PROBE_DOWN))
        begin
            rd_data_reg <= mem[probe_idx];
            rd_idx_reg  <= probe_idx;
        end
    end

    // Control state: load index, covered bits, held and output valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg   <= '0;
            cov_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // The output is set when a result is loaded and cleared when taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                gtrm_pkg::OP_LOAD:
                begin
                    if (last_tile)
                    begin
                        load_idx_reg   <= '0;
                        cov_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                    end
                    else if (load_idx_reg == IDX_W'(CELL_COUNT - 1))
                    begin
                        load_idx_reg <= '0;
                    end
                    else
                    begin
                        load_idx_reg <= load_idx_reg + IDX_W'(1);
                    end
                end
                gtrm_pkg::OP_TAKE_START, gtrm_pkg::OP_RUN_GROW:
                begin
                    cov_reg[rd_idx_reg] <= 1'b1;
                end
                gtrm_pkg::OP_DOWN_GROW:
                begin
                    cov_reg <= cov_reg | row_mask;
                end
                gtrm_pkg::OP_PUSH:
                begin
                    pend_valid_reg <= 1'b1;
                end
                gtrm_pkg::OP_FLUSH:
                begin
                    pend_valid_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload: counters, merge limit, held rectangle and output fields.
    always_ff @(posedge clk)
    begin
        case (op)
            gtrm_pkg::OP_LOAD:
            begin
                if (last_tile)
                begin
                    limit_reg <= load_idx_reg;
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                end
            end
            gtrm_pkg::OP_TAKE_START:
            begin
                typ_reg <= eff_type;
                rw_reg  <= gtrm_pkg::EXT_W'(1);
                rh_reg  <= gtrm_pkg::EXT_W'(1);
                ri_reg  <= '0;
            end
            gtrm_pkg::OP_RUN_GROW:
            begin
                rw_reg <= rw_reg + gtrm_pkg::EXT_W'(1);
            end
            gtrm_pkg::OP_DOWN_STEP:
            begin
                ri_reg <= ri_reg + gtrm_pkg::EXT_W'(1);
            end
            gtrm_pkg::OP_DOWN_GROW:
            begin
                rh_reg <= rh_reg + gtrm_pkg::EXT_W'(1);
                ri_reg <= '0;
            end
            gtrm_pkg::OP_ADVANCE, gtrm_pkg::OP_PUSH:
            begin
                if (op == gtrm_pkg::OP_PUSH)
                begin
                    if (pend_valid_reg)
                    begin
                        out_type_reg <= pend_type_reg;
                        out_x_reg    <= pend_x_reg;
                        out_y_reg    <= pend_y_reg;
                        out_w_reg    <= pend_w_reg;
                        out_h_reg    <= pend_h_reg;
                        out_rv_reg   <= 1'b1;
                        out_last_reg <= 1'b0;
                    end
                    pend_type_reg <= typ_reg;
                    pend_x_reg    <= cx_reg;
                    pend_y_reg    <= cy_reg;
                    pend_w_reg    <= rw_reg;
                    pend_h_reg    <= rh_reg;
                end
                if (col_last)
                begin
                    cx_reg <= '0;
                    cy_reg <= cy_reg + gtrm_pkg::COORD_W'(1);
                end
                else
                begin
                    cx_reg <= cx_reg + gtrm_pkg::COORD_W'(1);
                end
            end
            gtrm_pkg::OP_FLUSH:
            begin
                // An empty grid yields one all-zero result marked invalid.
                out_type_reg <= pend_valid_reg ? pend_type_reg : '0;
                out_x_reg    <= pend_valid_reg ? pend_x_reg : '0;
                out_y_reg    <= pend_valid_reg ? pend_y_reg : '0;
                out_w_reg    <= pend_valid_reg ? pend_w_reg : '0;
                out_h_reg    <= pend_valid_reg ? pend_h_reg : '0;
                out_rv_reg   <= pend_valid_reg;
                out_last_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign rect_type   = out_type_reg;
    assign rect_x      = out_x_reg;
    assign rect_y      = out_y_reg;
    assign rect_width  = out_w_reg;
    assign rect_height = out_h_reg;
    assign rect_valid  = out_rv_reg;
    assign last_rect   = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/greedy_tile_rect_merge.sv -----
// Tiles load at one item per cycle while the block is in its load phase.
// Merging reads and checks each scanned cell and each run or row probe, checks room before each
// probe and pushes each rectangle, then flushes; the final result and ready return together.
// Each rectangle is held until the next is found; output stalls hold the merge in place.
// Reset clears the load index, covered bits and valid flags; tile memory is not reset.
// ----------------------------------------------------------------------------
// Greedy tile rectangle merge: top level
// Loads a tile grid and emits the greedy rectangle cover of its nonempty cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_tile_rect_merge_defines.svh"

module greedy_tile_rect_merge #(
    parameter int GRID_WIDTH  = gtrm_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gtrm_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gtrm_pkg::TYPE_W-1:0]   tile_type,
    input  wire logic                          last_tile,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gtrm_pkg::TYPE_W-1:0]        rect_type,
    output logic [gtrm_pkg::COORD_W-1:0]       rect_x,
    output logic [gtrm_pkg::COORD_W-1:0]       rect_y,
    output logic [gtrm_pkg::EXT_W-1:0]         rect_width,
    output logic [gtrm_pkg::EXT_W-1:0]         rect_height,
    output logic                               rect_valid,
    output logic                               last_rect
);

    gtrm_pkg::dp_status_t status;
    gtrm_pkg::dp_op_t     op;

    // Controller.
    gtrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_tile (last_tile),
        .in_ready  (in_ready),
        .status    (status),
        .op        (op)
    );

    // Datapath.
    gtrm_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .tile_type   (tile_type),
        .last_tile   (last_tile),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rect_type   (rect_type),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .rect_valid  (rect_valid),
        .last_rect   (last_rect)
    );

    // A tile is written only when it is really accepted.
    `GTRM_ASSERT_IMPLY(a_load_on_accept, op == gtrm_pkg::OP_LOAD, in_valid && in_ready, "tile written without accept")

    // The final tile ends the load phase.
    `GTRM_ASSERT_NEXT(a_last_stops_load, in_valid && in_ready && last_tile, !in_ready, "load continued after final tile")

    // A real rectangle has a nonzero extent in both directions.
    `GTRM_ASSERT_IMPLY(a_rect_extent, out_valid && rect_valid, (rect_width != 0) && (rect_height != 0), "empty rectangle emitted")

    // The empty-grid marker is always final and all zero.
    `GTRM_ASSERT_IMPLY(a_empty_marker, out_valid && !rect_valid, last_rect && (rect_width == 0) && (rect_type == 0), "bad empty-grid result")

endmodule

`default_nettype wire
